// ===== design/pfe_pkg.sv =====
// Shared constants and helpers for the prime field exponentiation unit.
// Holds the fixed prime, command and storage slot codes, and small lookups.
// Used by prime_field_fixed_exponentiation; depends on nothing else.
package pfe_pkg;

  // The fixed 502-bit prime, least significant limb in the low bits.
  localparam logic [511:0] PRIME = {
    64'h00255946A8869BC6, 64'h8C15B0036936E792,
    64'h02BDBE6326507D01, 64'hFE3AC5904A0DEA65,
    64'hFAF0A29A781974CE, 64'h994C68ADA6E1FFFF,
    64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF
  };

  // Command codes carried in tuser of the input stream.
  localparam logic [1:0] CMD_INV  = 2'd0;
  localparam logic [1:0] CMD_SQRT = 2'd1;
  localparam logic [1:0] CMD_TEST = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Slots of the field element memory, and operand sources of a product.
  localparam logic [1:0] SLOT_BASE = 2'd0;
  localparam logic [1:0] SLOT_POW  = 2'd1;
  localparam logic [1:0] SLOT_PROD = 2'd2;
  // As a multiplicand source this code selects the loaded operand words.
  localparam logic [1:0] SRC_RAW   = 2'd3;
  // As a multiplier source this code selects the constant one.
  localparam logic [1:0] SRC_UNIT  = 2'd3;

  localparam logic [3:0] LAST_LIMB  = 4'd15;
  localparam logic [2:0] LAST_WORD  = 3'd7;
  localparam logic [8:0] CHAIN_LAST = 9'd509;
  localparam logic [8:0] DBL_LAST   = 9'd511;

  // One 32-bit limb of the prime.
  function automatic logic [31:0] prime_limb(input logic [3:0] j);
    return PRIME[{j, 5'b0} +: 32];
  endfunction

  // One bit of the prime.
  function automatic logic prime_bit(input logic [8:0] b);
    return PRIME[b];
  endfunction

  // Multiplier source of each finishing product; the multiplicand is the product slot.
  function automatic logic [1:0] fin_b(input logic [1:0] cmd, input logic [1:0] step);
    logic [1:0] r;
    r = SLOT_PROD;
    if (cmd == CMD_SQRT) begin
      r = SLOT_BASE;
    end else if (cmd == CMD_INV) begin
      r = (step == 2'd2) ? SLOT_BASE : SLOT_PROD;
    end else if (step == 2'd1) begin
      r = SLOT_BASE;
    end else if (step == 2'd2) begin
      r = SRC_UNIT;
    end
    return r;
  endfunction

  // True on the last finishing product of a command.
  function automatic logic fin_last(input logic [1:0] cmd, input logic [1:0] step);
    return (cmd == CMD_SQRT) || (step == 2'd2);
  endfunction

endpackage

// ===== design/prime_field_fixed_exponentiation.sv =====
// Top level of the prime field exponentiation unit (inverse, square root, residue test).
// Word-serial Montgomery engine over on-chip memories with registered read data.
// Depends on pfe_pkg.
//
// The block takes eight 64-bit operand beats, least significant first, in
// Montgomery form; tuser carries the command and tlast marks the final beat,
// which starts the work. Inverse and square root return eight result beats,
// the residue test one beat with the answer in tuser. One operation at a time:
// the input side waits while an operation runs. All arithmetic runs on 32-bit
// limbs through a single 32x32 multiplier. A Montgomery product takes one
// multiply-accumulate and reduce pass per limb of b, then a pass that stores
// the sum and, when a subtraction is needed, one that keeps its difference
// with p. One operation builds R mod p by 512 doublings, then runs 2 + 510 +
// 312 (one for each set bit of p above bit 1) + 1 to 3 products.
module prime_field_fixed_exponentiation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_word
  input  logic [1:0]  s_tuser,   // cmd
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // result_word
  output logic [0:0]  m_tuser,   // is_square
  output logic        m_tlast
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_OINIT = 4'd1;
  localparam logic [3:0] ST_ODBL  = 4'd2;
  localparam logic [3:0] ST_BI    = 4'd3;
  localparam logic [3:0] ST_BIW   = 4'd4;
  localparam logic [3:0] ST_PA    = 4'd5;
  localparam logic [3:0] ST_PB    = 4'd6;
  localparam logic [3:0] ST_BF    = 4'd7;
  localparam logic [3:0] ST_PS    = 4'd8;
  localparam logic [3:0] ST_PC    = 4'd9;
  localparam logic [3:0] ST_CMP   = 4'd10;
  localparam logic [3:0] ST_FLAG  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  localparam logic [2:0] PH_ONE  = 3'd0;
  localparam logic [2:0] PH_BASE = 3'd1;
  localparam logic [2:0] PH_POW  = 3'd2;
  localparam logic [2:0] PH_CHM  = 3'd3;
  localparam logic [2:0] PH_CHS  = 3'd4;
  localparam logic [2:0] PH_FIN  = 3'd5;

  // Control registers.
  logic [3:0]  st;
  logic [2:0]  phase;
  logic [4:0]  jc;
  logic [3:0]  i;
  logic [1:0]  mul_a, mul_b, mul_dst;
  logic [1:0]  pend_cmd;
  logic [2:0]  load_cnt;
  logic [8:0]  idx;
  logic [8:0]  dbl_cnt;
  logic [1:0]  fs;
  logic [2:0]  k;
  logic [1:0]  os;

  // Datapath registers.
  logic [31:0] bi, c, m_reg, t16, lo_word, hi_word;
  logic        t17, borrow, eq, rd_half;
  logic [32:0] tops;

  // Memories.
  logic [31:0] fmem [48];
  logic [31:0] tmem [16];
  logic [63:0] opmem [8];
  logic [31:0] f_q, t_q;
  logic [63:0] op_q;

  logic        f_we, t_we;
  logic [5:0]  f_raddr, f_waddr;
  logic [31:0] f_wd, t_wd;
  logic [3:0]  t_waddr;

  logic [3:0]  pj;
  logic [31:0] a_j, p_j, m_cur, mul_x, mul_y, addend;
  logic [63:0] u;
  logic [32:0] diff, top_sum;
  logic        sub_need, eng_done, out_free, out_load;

  logic [3:0]  adv_st;
  logic [2:0]  adv_phase;
  logic [1:0]  adv_a, adv_b, adv_dst, adv_fs;
  logic [8:0]  adv_idx, adv_dbl, cv;

  assign s_tready = (st == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((st == ST_FLAG) || (st == ST_OUT && os == 2'd3));
  assign pj       = jc[3:0] - 4'd1;

  // Shared limb arithmetic: one multiply-accumulate and one subtract.
  assign a_j     = (mul_a == pfe_pkg::SRC_RAW) ? (rd_half ? op_q[63:32] : op_q[31:0]) : f_q;
  assign p_j     = pfe_pkg::prime_limb(pj);
  assign m_cur   = (pj == 4'd0) ? t_q : m_reg;
  assign mul_x   = (st == ST_PB) ? m_cur : a_j;
  assign mul_y   = (st == ST_PB) ? p_j : bi;
  assign addend  = (st == ST_PA && i == 4'd0) ? 32'd0 : t_q;
  assign u       = 64'(mul_x) * 64'(mul_y) + {32'd0, addend} + {32'd0, c};
  assign top_sum = {1'b0, t16} + {1'b0, u[63:32]};
  assign diff    = {1'b0, t_q} - {1'b0, p_j} - {32'd0, borrow};
  assign sub_need = (t16 != 32'd0) || !diff[32];
  assign eng_done = (jc == 5'd16) && ((st == ST_PS && !sub_need) || st == ST_PC);

  // Read address of the field element memory.
  always_comb begin
    unique case (st)
      ST_BI:   f_raddr = {mul_b, i};
      ST_PA:   f_raddr = {mul_a, jc[3:0]};
      ST_OUT:  f_raddr = {pfe_pkg::SLOT_PROD, k, os[0]};
      default: f_raddr = {pfe_pkg::SLOT_PROD, jc[3:0]};
    endcase
  end

  // Write port of the field element memory.
  always_comb begin
    f_we    = 1'b0;
    f_waddr = {mul_dst, pj};
    f_wd    = t_q;
    unique case (st)
      ST_OINIT: begin
        f_we    = 1'b1;
        f_waddr = {pfe_pkg::SLOT_PROD, jc[3:0]};
        f_wd    = (jc == 5'd0) ? 32'd1 : 32'd0;
      end
      ST_PS:   f_we = (jc != 5'd0);
      ST_PC:   f_we = (jc != 5'd0);
      default: f_we = 1'b0;
    endcase
  end

  // Write port of the accumulator memory.
  always_comb begin
    t_we    = 1'b0;
    t_waddr = pj;
    t_wd    = u[31:0];
    unique case (st)
      ST_PA: t_we = (jc != 5'd0);
      ST_PB: begin
        t_we    = (jc != 5'd0) && (pj != 4'd0);
        t_waddr = pj - 4'd1;
      end
      ST_BF: begin
        t_we    = 1'b1;
        t_waddr = pfe_pkg::LAST_LIMB;
        t_wd    = tops[31:0];
      end
      ST_PS: begin
        t_we = (jc != 5'd0);
        t_wd = diff[31:0];
      end
      ST_ODBL: begin
        t_we = (jc != 5'd0);
        t_wd = {f_q[30:0], c[0]};
      end
      default: t_we = 1'b0;
    endcase
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wd;
    end
    f_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wd;
    end
    t_q <= tmem[jc[3:0]];
  end

  always_ff @(posedge clk) begin
    if (st == ST_IDLE && s_tvalid) begin
      opmem[load_cnt] <= s_tdata;
    end
    op_q    <= opmem[jc[3:1]];
    rd_half <= jc[0];
  end

  // Next product of the sequence once the engine finishes one.
  always_comb begin
    adv_st    = ST_BI;
    adv_phase = phase;
    adv_a     = pfe_pkg::SLOT_PROD;
    adv_b     = pfe_pkg::SLOT_PROD;
    adv_dst   = pfe_pkg::SLOT_PROD;
    adv_idx   = idx;
    adv_fs    = fs;
    adv_dbl   = dbl_cnt;
    cv        = (phase == PH_POW) ? 9'd0 : idx + 9'd1;
    unique case (phase)
      PH_ONE: begin
        if (dbl_cnt == pfe_pkg::DBL_LAST) begin
          adv_phase = PH_BASE;
          adv_a     = pfe_pkg::SRC_RAW;
          adv_dst   = pfe_pkg::SLOT_BASE;
        end else begin
          adv_st  = ST_ODBL;
          adv_dbl = dbl_cnt + 9'd1;
        end
      end
      PH_BASE: begin
        adv_phase = PH_POW;
        adv_a     = pfe_pkg::SRC_RAW;
        adv_dst   = pfe_pkg::SLOT_POW;
      end
      PH_CHM: begin
        adv_phase = PH_CHS;
        adv_a     = pfe_pkg::SLOT_POW;
        adv_b     = pfe_pkg::SLOT_POW;
        adv_dst   = pfe_pkg::SLOT_POW;
      end
      PH_FIN: begin
        if (pfe_pkg::fin_last(pend_cmd, fs)) begin
          adv_st = (pend_cmd == pfe_pkg::CMD_TEST) ? ST_CMP : ST_OUT;
        end else begin
          adv_fs = fs + 2'd1;
          adv_b  = pfe_pkg::fin_b(pend_cmd, fs + 2'd1);
        end
      end
      default: begin
        // Power setup done or a square of the chain done: pick the next chain step.
        if (phase == PH_CHS && idx == pfe_pkg::CHAIN_LAST) begin
          adv_phase = PH_FIN;
          adv_fs    = 2'd0;
          adv_b     = pfe_pkg::fin_b(pend_cmd, 2'd0);
        end else begin
          adv_idx = cv;
          if (pfe_pkg::prime_bit(cv + 9'd2)) begin
            adv_phase = PH_CHM;
            adv_b     = pfe_pkg::SLOT_POW;
          end else begin
            adv_phase = PH_CHS;
            adv_a     = pfe_pkg::SLOT_POW;
            adv_b     = pfe_pkg::SLOT_POW;
            adv_dst   = pfe_pkg::SLOT_POW;
          end
        end
      end
    endcase
  end

  // Sequencer, limb passes and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      phase    <= PH_ONE;
      jc       <= 5'd0;
      i        <= 4'd0;
      mul_a    <= pfe_pkg::SLOT_PROD;
      mul_b    <= pfe_pkg::SLOT_PROD;
      mul_dst  <= pfe_pkg::SLOT_PROD;
      pend_cmd <= pfe_pkg::CMD_INV;
      load_cnt <= 3'd0;
      idx      <= 9'd0;
      dbl_cnt  <= 9'd0;
      fs       <= 2'd0;
      k        <= 3'd0;
      os       <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      // A new result beat takes the register; otherwise an accepted beat leaves it.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (s_tvalid) begin
            load_cnt <= load_cnt + 3'd1;
            pend_cmd <= s_tuser;
            if (s_tlast) begin
              load_cnt <= 3'd0;
              if (s_tuser != pfe_pkg::CMD_NONE) begin
                st      <= ST_OINIT;
                jc      <= 5'd0;
                phase   <= PH_ONE;
                dbl_cnt <= 9'd0;
                mul_dst <= pfe_pkg::SLOT_PROD;
              end
            end
          end
        end
        ST_OINIT: begin
          // Seed the product slot with one before the doublings.
          jc <= jc + 5'd1;
          if (jc == 5'd15) begin
            st <= ST_ODBL;
            jc <= 5'd0;
            c  <= 32'd0;
          end
        end
        ST_ODBL: begin
          jc <= jc + 5'd1;
          if (jc != 5'd0) begin
            c <= {31'd0, f_q[31]};
          end
          if (jc == 5'd16) begin
            t16    <= {31'd0, f_q[31]};
            st     <= ST_PS;
            jc     <= 5'd0;
            borrow <= 1'b0;
          end
        end
        ST_BI: st <= ST_BIW;
        ST_BIW: begin
          if (mul_b == pfe_pkg::SRC_UNIT) begin
            bi <= (i == 4'd0) ? 32'd1 : 32'd0;
          end else begin
            bi <= f_q;
          end
          c  <= 32'd0;
          jc <= 5'd0;
          st <= ST_PA;
        end
        ST_PA: begin
          // Accumulate a times one limb of b.
          jc <= jc + 5'd1;
          if (jc != 5'd0) begin
            c <= u[63:32];
          end
          if (jc == 5'd16) begin
            {t17, t16} <= top_sum;
            c  <= 32'd0;
            jc <= 5'd0;
            st <= ST_PB;
          end
        end
        ST_PB: begin
          // Add m times p and drop the low limb.
          jc <= jc + 5'd1;
          if (jc == 5'd1) begin
            m_reg <= t_q;
          end
          if (jc != 5'd0) begin
            c <= u[63:32];
          end
          if (jc == 5'd16) begin
            tops <= top_sum;
            st   <= ST_BF;
          end
        end
        ST_BF: begin
          t16 <= {31'd0, t17} + {31'd0, tops[32]};
          t17 <= 1'b0;
          jc  <= 5'd0;
          if (i == pfe_pkg::LAST_LIMB) begin
            st     <= ST_PS;
            borrow <= 1'b0;
          end else begin
            i  <= i + 4'd1;
            st <= ST_BI;
          end
        end
        ST_PS, ST_PC: begin
          // Store the sum and its difference with p; keep the difference if needed.
          jc <= jc + 5'd1;
          if (st == ST_PS && jc != 5'd0) begin
            borrow <= diff[32];
          end
          if (st == ST_PS && jc == 5'd16 && sub_need) begin
            st <= ST_PC;
            jc <= 5'd0;
          end
          if (eng_done) begin
            st      <= adv_st;
            phase   <= adv_phase;
            mul_a   <= adv_a;
            mul_b   <= adv_b;
            mul_dst <= adv_dst;
            idx     <= adv_idx;
            fs      <= adv_fs;
            dbl_cnt <= adv_dbl;
            jc      <= 5'd0;
            i       <= 4'd0;
            t16     <= 32'd0;
            t17     <= 1'b0;
            c       <= 32'd0;
            eq      <= 1'b1;
            k       <= 3'd0;
            os      <= 2'd0;
          end
        end
        ST_CMP: begin
          // Compare the product with one, limb by limb.
          jc <= jc + 5'd1;
          if (jc != 5'd0) begin
            eq <= eq && (f_q == ((pj == 4'd0) ? 32'd1 : 32'd0));
          end
          if (jc == 5'd16) begin
            st <= ST_FLAG;
          end
        end
        ST_FLAG: begin
          if (out_free) begin
            m_tdata  <= 64'd0;
            m_tuser  <= eq;
            m_tlast  <= 1'b1;
            st       <= ST_IDLE;
          end
        end
        ST_OUT: begin
          // Two limb reads make one result beat.
          unique case (os)
            2'd0: os <= 2'd1;
            2'd1: begin
              lo_word <= f_q;
              os      <= 2'd2;
            end
            2'd2: begin
              hi_word <= f_q;
              os      <= 2'd3;
            end
            default: begin
              if (out_free) begin
                m_tdata  <= {hi_word, lo_word};
                m_tuser  <= 1'b0;
                m_tlast  <= (k == pfe_pkg::LAST_WORD);
                os       <= 2'd0;
                if (k == pfe_pkg::LAST_WORD) begin
                  st <= ST_IDLE;
                end else begin
                  k <= k + 3'd1;
                end
              end
            end
          endcase
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for prime_field_fixed_exponentiation.
// It predicts each run with a bit-serial Montgomery model and checks every result beat.
// Depends on pfe_pkg and the block's top level.
`timescale 1ns / 1ps

typedef struct {
  logic [63:0] word;
  logic        square;
  logic        last;
} result_beat_t;

class exp_scoreboard;
  logic [63:0]  slots[8];
  int unsigned  slot_count;
  result_beat_t awaited[$];
  int unsigned  mismatches;

  function new();
    slot_count = 0;
    mismatches = 0;
    foreach (slots[i]) slots[i] = '0;
  endfunction

  // Montgomery product a*b/2^512 mod p, fully reduced; b must be below p.
  function automatic logic [511:0] mont_mul(logic [511:0] a, logic [511:0] b);
    logic [513:0] acc;
    acc = '0;
    for (int i = 0; i < 512; i++) begin
      if (a[i]) acc = acc + b;
      if (acc[0]) acc = acc + pfe_pkg::PRIME;
      acc = acc >> 1;
    end
    if (acc >= pfe_pkg::PRIME) acc = acc - pfe_pkg::PRIME;
    return acc[511:0];
  endfunction

  // Notes one accepted operand beat and predicts the results it causes.
  function void note_operand(logic [1:0] cmd, logic [63:0] word, logic last);
    logic [511:0] raw, one, base, power, prod, t, unit;
    logic [513:0] r_mod;
    result_beat_t rb;
    slots[slot_count] = word;
    slot_count = (slot_count + 1) % 8;
    if (!last) return;
    slot_count = 0;
    for (int k = 0; k < 8; k++) raw[64*k +: 64] = slots[k];
    r_mod = (514'b1 << 512) % pfe_pkg::PRIME;
    one = r_mod[511:0];
    base = mont_mul(raw, one);
    power = base;
    prod = one;
    for (int idx = 0; idx < 510; idx++) begin
      if (pfe_pkg::PRIME[idx + 2]) prod = mont_mul(prod, power);
      power = mont_mul(power, power);
    end
    t = prod;
    unit = 512'd1;
    case (cmd)
      pfe_pkg::CMD_TEST: begin
        t = mont_mul(t, t);
        t = mont_mul(t, base);
        t = mont_mul(t, unit);
        rb.word = '0;
        rb.square = (t == unit);
        rb.last = 1'b1;
        awaited.push_back(rb);
        return;
      end
      pfe_pkg::CMD_INV: begin
        t = mont_mul(t, t);
        t = mont_mul(t, t);
        t = mont_mul(t, base);
      end
      pfe_pkg::CMD_SQRT: t = mont_mul(t, base);
      default: return;
    endcase
    for (int k = 0; k < 8; k++) begin
      rb.word = t[64*k +: 64];
      rb.square = 1'b0;
      rb.last = (k == 7);
      awaited.push_back(rb);
    end
  endfunction

  // Compares one result beat with the oldest prediction.
  function void check_result(logic [63:0] word, logic square, logic last);
    result_beat_t rb;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result beat %h %b %b", word, square, last);
      return;
    end
    rb = awaited.pop_front();
    if (rb.word !== word || rb.square !== square || rb.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Result mismatch: expected %h sq %b last %b, got %h sq %b last %b",
                 rb.word, rb.square, rb.last, word, square, last);
    end
  endfunction
endclass

module tb_top;

  localparam longint unsigned CYCLE_LIMIT = 64'd300_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = pfe_pkg::CMD_INV;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  exp_scoreboard sb = new();
  int unsigned   send_idle_pct = 30;
  int unsigned   recv_idle_pct = 86;
  int unsigned   beats_sent = 0;
  int unsigned   beats_received = 0;
  longint unsigned cycles = 0;

  prime_field_fixed_exponentiation dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver side: random stalls, with one long hold-off early on.
  initial begin
    forever begin
      @(posedge clk);
      if (beats_received == 3 && m_tvalid && m_tready) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result beats are checked as they are accepted.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata, m_tuser[0], m_tlast);
      beats_received <= beats_received + 1;
    end
  end

  // Offers one operand beat and waits for it to be taken.
  task automatic send_beat(logic [1:0] cmd, logic [63:0] word, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= cmd;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_operand(cmd, word, last);
    beats_sent++;
  endtask

  // Sends a run of n beats; kind 0 random, 1 zero, 2 all ones, 3 prime words.
  task automatic send_run(logic [1:0] cmd, int n, logic with_last, int kind);
    logic [63:0] w;
    for (int k = 0; k < n; k++) begin
      case (kind)
        1: w = '0;
        2: w = '1;
        3: w = pfe_pkg::PRIME[64*(k % 8) +: 64];
        default: w = {$urandom, $urandom};
      endcase
      send_beat(cmd, w, with_last && (k == n - 1));
    end
  endtask

  initial begin
    int r;
    int len;
    logic [1:0] c;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: full loads first, so every slot holds a written value.
    send_run(pfe_pkg::CMD_INV, 8, 1'b1, 2);   // all ones, above p
    send_run(pfe_pkg::CMD_NONE, 2, 1'b1, 0);  // unused command ends the load only
    send_run(pfe_pkg::CMD_SQRT, 8, 1'b1, 1);  // zero operand
    send_run(pfe_pkg::CMD_TEST, 8, 1'b1, 3);  // operand equal to p
    send_run(pfe_pkg::CMD_TEST, 3, 1'b1, 0);  // early last mark

    // Random runs, mostly well formed, with idling phases by beat count.
    while (beats_sent < 85) begin
      if (beats_sent > 65) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (beats_sent > 45) begin
        send_idle_pct = 86;
        recv_idle_pct = 30;
      end
      r = int'($urandom_range(99));
      c = 2'($urandom_range(2));
      if (r < 75) begin
        send_run(c, 8, 1'b1, 0);
      end else if (r < 85) begin
        len = int'($urandom_range(5, 1));
        send_run(c, len, 1'b1, 0);
      end else if (r < 95) begin
        len = int'($urandom_range(12, 9));
        for (int k = 0; k < len; k++)
          send_beat(2'($urandom_range(3)), {$urandom, $urandom}, 1'b0);
      end else begin
        send_run(pfe_pkg::CMD_NONE, 8, 1'b1, 0);
      end
    end
    send_run(pfe_pkg::CMD_SQRT, 8, 1'b1, 0);
    s_tvalid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
